// ===== rtl/ptfc_pkg.sv =====
// types and constants shared by the push-to-talk floor control block
package ptfc_pkg;

  localparam int unsigned CntW = 16;
  localparam logic [CntW-1:0] CntMax = '1;
  localparam logic [CntW-1:0] DebounceRst = 16'd30;
  localparam logic [CntW-1:0] TimeoutRst = 16'd2500;

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_TIMEOUT  = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_LINK_UP   = 3'd1,
    OP_LINK_DOWN = 3'd2,
    OP_GRANT     = 3'd3,
    OP_DENY      = 3'd4,
    OP_REVOKE    = 3'd5,
    OP_NONE      = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    FLOOR_IDLE       = 2'd0,
    FLOOR_REQUESTING = 2'd1,
    FLOOR_HOLDING    = 2'd2
  } floor_e;

  typedef enum logic [1:0] {
    MSG_NONE    = 2'd0,
    MSG_REQUEST = 2'd1,
    MSG_RELEASE = 2'd2,
    MSG_HELLO   = 2'd3
  } msg_e;

  typedef struct packed {
    logic [2:0] op;
    logic       key_down;
  } in_t;

  typedef struct packed {
    logic [1:0] send_msg;
    logic [1:0] floor;
    logic       capture_on;
  } out_t;

  typedef struct packed {
    logic [1:0]      floor_state;
    logic            link_up;
    logic            key_stable;
    logic [CntW-1:0] ms_since_key_change;
    logic [CntW-1:0] ms_since_request;
  } state_t;

  typedef struct packed {
    logic [CntW-1:0] debounce_ms;
    logic [CntW-1:0] request_timeout_ms;
  } cfg_t;

endpackage

// ===== rtl/ptfc_next.sv =====
// next floor state and result word for one event
module ptfc_next (
  input  ptfc_pkg::in_t    word_i,
  input  ptfc_pkg::state_t state_i,
  input  ptfc_pkg::cfg_t   cfg_i,
  output ptfc_pkg::state_t state_o,
  output ptfc_pkg::out_t   word_o
);

  logic [ptfc_pkg::CntW-1:0] key_cnt;
  logic [ptfc_pkg::CntW-1:0] req_cnt;
  logic [1:0]                msg;
  ptfc_pkg::state_t          nxt;

  assign key_cnt = (state_i.ms_since_key_change == ptfc_pkg::CntMax) ?
                   ptfc_pkg::CntMax : state_i.ms_since_key_change + 1'b1;
  assign req_cnt = (state_i.ms_since_request == ptfc_pkg::CntMax) ?
                   ptfc_pkg::CntMax : state_i.ms_since_request + 1'b1;

  always_comb begin
    nxt = state_i;
    msg = ptfc_pkg::MSG_NONE;
    unique case (word_i.op)
      ptfc_pkg::OP_TICK: begin
        nxt.ms_since_key_change = key_cnt;
        nxt.ms_since_request    = req_cnt;
        if ((word_i.key_down != state_i.key_stable) && (key_cnt > cfg_i.debounce_ms)) begin
          nxt.key_stable          = word_i.key_down;
          nxt.ms_since_key_change = '0;
          if (word_i.key_down) begin
            if (state_i.link_up && (state_i.floor_state == ptfc_pkg::FLOOR_IDLE)) begin
              nxt.floor_state      = ptfc_pkg::FLOOR_REQUESTING;
              nxt.ms_since_request = '0;
              msg                  = ptfc_pkg::MSG_REQUEST;
            end
          end else begin
            if (state_i.floor_state != ptfc_pkg::FLOOR_IDLE) begin
              msg = ptfc_pkg::MSG_RELEASE;
            end
            nxt.floor_state = ptfc_pkg::FLOOR_IDLE;
          end
        end
        if ((nxt.floor_state == ptfc_pkg::FLOOR_REQUESTING) &&
            (nxt.ms_since_request > cfg_i.request_timeout_ms)) begin
          nxt.floor_state = ptfc_pkg::FLOOR_IDLE;
        end
      end
      ptfc_pkg::OP_LINK_UP: begin
        nxt.link_up = 1'b1;
        msg         = ptfc_pkg::MSG_HELLO;
      end
      ptfc_pkg::OP_LINK_DOWN: begin
        nxt.link_up     = 1'b0;
        nxt.floor_state = ptfc_pkg::FLOOR_IDLE;
      end
      ptfc_pkg::OP_GRANT: begin
        if (state_i.floor_state == ptfc_pkg::FLOOR_REQUESTING) begin
          nxt.floor_state = ptfc_pkg::FLOOR_HOLDING;
        end else begin
          msg = ptfc_pkg::MSG_RELEASE;
        end
      end
      ptfc_pkg::OP_DENY: begin
        if (state_i.floor_state == ptfc_pkg::FLOOR_REQUESTING) begin
          nxt.floor_state = ptfc_pkg::FLOOR_IDLE;
        end
      end
      ptfc_pkg::OP_REVOKE: begin
        if (state_i.floor_state == ptfc_pkg::FLOOR_HOLDING) begin
          nxt.floor_state = ptfc_pkg::FLOOR_IDLE;
        end
      end
      default: begin
        nxt = state_i;
      end
    endcase
  end

  assign state_o           = nxt;
  assign word_o.send_msg   = msg;
  assign word_o.floor      = nxt.floor_state;
  assign word_o.capture_on = (nxt.floor_state == ptfc_pkg::FLOOR_HOLDING);

endmodule

// ===== rtl/push_to_talk_floor_control.sv =====
// top level of the push-to-talk floor control block
// One event word in, one result word out, one word per clock sustained while
// out_stall_i is low. An event is captured in an input register, the floor
// state update is combinational, and the result lands in an output register
// backed by one skid entry, and input keeps flowing while a single result is
// held by out_stall_i. Configuration writes (index 0 debounce_ms, 1
// request_timeout_ms, others ignored) are always ready and should be done
// while no events are in flight.
module push_to_talk_floor_control (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ptfc_pkg::in_t                  in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ptfc_pkg::out_t                 out_word_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ptfc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ptfc_pkg::CntW-1:0]      cfg_data_i
);

  ptfc_pkg::cfg_t   cfg_q;
  ptfc_pkg::state_t state_q;
  ptfc_pkg::state_t state_d;
  ptfc_pkg::in_t    in_word_q;
  logic             in_valid_q;
  ptfc_pkg::out_t   res_d;
  ptfc_pkg::out_t   out_word_q;
  logic             out_valid_q;
  ptfc_pkg::out_t   skid_word_q;
  logic             skid_valid_q;
  logic             in_take;
  logic             push;
  logic             pop;

  assign cfg_ready_o = 1'b1;
  assign push        = in_valid_q & ~skid_valid_q;
  assign pop         = out_valid_q & ~out_stall_i;
  assign in_stall_o  = in_valid_q & skid_valid_q;
  assign in_take     = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  ptfc_next u_next (
    .word_i  (in_word_q),
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .state_o (state_d),
    .word_o  (res_d)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms        <= ptfc_pkg::DebounceRst;
      cfg_q.request_timeout_ms <= ptfc_pkg::TimeoutRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == ptfc_pkg::CFG_DEBOUNCE) begin
        cfg_q.debounce_ms <= cfg_data_i;
      end
      if (cfg_index_i == ptfc_pkg::CFG_TIMEOUT) begin
        cfg_q.request_timeout_ms <= cfg_data_i;
      end
    end
  end

  // floor state and input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.floor_state         <= ptfc_pkg::FLOOR_IDLE;
      state_q.link_up             <= 1'b0;
      state_q.key_stable          <= 1'b0;
      state_q.ms_since_key_change <= '0;
      state_q.ms_since_request    <= '0;
      in_valid_q                  <= 1'b0;
    end else begin
      if (push) begin
        state_q <= state_d;
      end
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (push) begin
        in_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_word_i;
    end
  end

  // result register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (push) begin
        if (out_valid_q && !pop) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (pop) begin
        out_valid_q  <= skid_valid_q;
        skid_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      if (out_valid_q && !pop) begin
        skid_word_q <= res_d;
      end else begin
        out_word_q <= res_d;
      end
    end else if (pop) begin
      out_word_q <= skid_word_q;
    end
  end

endmodule

// ===== dv/push_to_talk_floor_control_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the push-to-talk floor control block, random event traffic
module push_to_talk_floor_control_tb;
  import ptfc_pkg::*;

  localparam logic [2:0]  OpUnused      = 3'd7;
  localparam int unsigned CycleLimit    = 4_000_000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned MaxReports    = 60;
  localparam int unsigned PhaseWords    = 140;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC
  } stall_mode_e;

  class floor_scoreboard;
    logic [CntW-1:0] debounce_ms;
    logic [CntW-1:0] timeout_ms;
    floor_e          floor_st;
    logic            link;
    logic            key_st;
    logic [CntW-1:0] key_age;
    logic [CntW-1:0] req_age;
    out_t            expected_q[$];
    int unsigned     errors;

    function new();
      debounce_ms = DebounceRst;
      timeout_ms  = TimeoutRst;
      floor_st    = FLOOR_IDLE;
      link        = 1'b0;
      key_st      = 1'b0;
      key_age     = '0;
      req_age     = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CntW-1:0] data);
      if (idx == CFG_DEBOUNCE) begin
        debounce_ms = data;
      end else if (idx == CFG_TIMEOUT) begin
        timeout_ms = data;
      end
    endfunction

    function void note_input(in_t w);
      msg_e msg;
      out_t want;
      msg = MSG_NONE;
      case (w.op)
        OP_TICK: begin
          if (key_age != CntMax) key_age++;
          if (req_age != CntMax) req_age++;
          if (w.key_down != key_st && key_age > debounce_ms) begin
            key_st  = w.key_down;
            key_age = '0;
            if (w.key_down) begin
              if (link && floor_st == FLOOR_IDLE) begin
                floor_st = FLOOR_REQUESTING;
                req_age  = '0;
                msg      = MSG_REQUEST;
              end
            end else begin
              if (floor_st != FLOOR_IDLE) msg = MSG_RELEASE;
              floor_st = FLOOR_IDLE;
            end
          end
          if (floor_st == FLOOR_REQUESTING && req_age > timeout_ms) floor_st = FLOOR_IDLE;
        end
        OP_LINK_UP: begin
          link = 1'b1;
          msg  = MSG_HELLO;
        end
        OP_LINK_DOWN: begin
          link     = 1'b0;
          floor_st = FLOOR_IDLE;
        end
        OP_GRANT: begin
          if (floor_st == FLOOR_REQUESTING) floor_st = FLOOR_HOLDING;
          else msg = MSG_RELEASE;
        end
        OP_DENY: begin
          if (floor_st == FLOOR_REQUESTING) floor_st = FLOOR_IDLE;
        end
        OP_REVOKE: begin
          if (floor_st == FLOOR_HOLDING) floor_st = FLOOR_IDLE;
        end
        default: begin
        end
      endcase
      want.send_msg   = msg;
      want.floor      = floor_st;
      want.capture_on = (floor_st == FLOOR_HOLDING);
      expected_q.push_back(want);
    endfunction

    function void mismatch(string field, logic [1:0] want, logic [1:0] got);
      errors++;
      if (errors <= MaxReports) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: result word with nothing expected, actual %h", $time, got);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.send_msg !== want.send_msg) mismatch("send_msg", want.send_msg, got.send_msg);
      if (got.floor !== want.floor) mismatch("floor", want.floor, got.floor);
      if (got.capture_on !== want.capture_on) begin
        mismatch("capture_on", 2'(want.capture_on), 2'(got.capture_on));
      end
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_t                in_word   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_t               out_word;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CntW-1:0]    cfg_data  = '0;

  floor_scoreboard sb;
  int unsigned     cycle_count   = 0;
  int unsigned     words_sent    = 0;
  int unsigned     burst_left    = 0;
  int unsigned     hold_requests = 0;
  int unsigned     holds_done    = 0;
  int unsigned     hold_left     = 0;
  int unsigned     mode_left     = 0;
  int unsigned     stall_phase   = 0;
  stall_mode_e     stall_mode    = STALL_NONE;

  push_to_talk_floor_control dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count++;

  always @(posedge clk) begin : result_side
    logic stall_next;
    if (rst_n && out_valid && !out_stall) sb.check_result(out_word);
    if (holds_done < hold_requests) begin
      holds_done++;
      hold_left = HoldOffCycles;
    end
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      mode_left  = $urandom_range(16, 240);
    end else begin
      mode_left--;
    end
    stall_phase = (stall_phase == 4) ? 0 : stall_phase + 1;
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE: begin
          stall_next = 1'b0;
        end
        STALL_RANDOM: begin
          stall_next = ($urandom_range(0, 2) == 0);
        end
        default: begin
          stall_next = (stall_phase < 2);
        end
      endcase
    end
    out_stall <= stall_next;
  end

  function automatic in_t event_word(logic [2:0] op, logic key);
    in_t w;
    w.op       = op;
    w.key_down = key;
    return w;
  endfunction

  function automatic int unsigned span(logic [CntW-1:0] v);
    return ((v > 12) ? 12 : int'(v)) + 3;
  endfunction

  task automatic send_word(input in_t w);
    if (burst_left == 0 && hold_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    sb.note_input(w);
    words_sent++;
  endtask

  task automatic tick(input logic key);
    send_word(event_word(OP_TICK, key));
  endtask

  task automatic post(input logic [2:0] op);
    send_word(event_word(op, 1'($urandom_range(0, 1))));
  endtask

  // held key level with occasional bounce and stray events
  task automatic key_tick(input logic level);
    if ($urandom_range(0, 9) == 0) post(3'($urandom_range(0, 7)));
    tick(($urandom_range(0, 7) == 0) ? !level : level);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic load_config(input logic [CntW-1:0] deb, input logic [CntW-1:0] tmo);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_data  <= deb;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(CFG_DEBOUNCE, deb);
    cfg_index <= CFG_TIMEOUT;
    cfg_data  <= tmo;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(CFG_TIMEOUT, tmo);
    cfg_valid <= 1'b0;
  endtask

  // press, server answer, hold, release
  task automatic talk_session();
    if ($urandom_range(0, 4) != 0) post(OP_LINK_UP);
    repeat ($urandom_range(1, span(sb.debounce_ms))) key_tick(1'b1);
    case ($urandom_range(0, 4))
      0, 1: begin
        post(OP_GRANT);
      end
      2: begin
        post(OP_DENY);
      end
      3: begin
      end
      default: begin
        post(OP_LINK_DOWN);
      end
    endcase
    repeat ($urandom_range(1, span(sb.timeout_ms))) key_tick(1'b1);
    if ($urandom_range(0, 3) == 0) post(OP_REVOKE);
    repeat ($urandom_range(1, span(sb.debounce_ms))) key_tick(1'b0);
  endtask

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : main_seq
    logic [CntW-1:0] phase_deb [8];
    logic [CntW-1:0] phase_tmo [8];
    int unsigned     target;
    sb = new();
    phase_deb = '{16'd0, CntMax, 16'd1, 16'd0, CntMax, 16'd0, 16'd0, 16'd0};
    phase_tmo = '{16'd0, CntMax, 16'd4, CntMax, 16'd0, 16'd0, 16'd0, 16'd0};
    for (int i = 5; i < 8; i++) begin
      phase_deb[i] = 16'($urandom_range(0, 6));
      phase_tmo[i] = 16'($urandom_range(0, 24));
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: stray messages, link handling, bounced key
    post(OP_NONE);
    post(OpUnused);
    post(OP_GRANT);
    post(OP_DENY);
    post(OP_REVOKE);
    post(OP_LINK_DOWN);
    tick(1'b1);
    post(OP_LINK_UP);
    post(OP_LINK_UP);

    load_config(16'd0, 16'd3);
    tick(1'b1);
    post(OP_DENY);
    tick(1'b0);
    tick(1'b1);
    post(OP_GRANT);
    post(OP_GRANT);
    post(OP_REVOKE);
    tick(1'b1);
    tick(1'b0);
    tick(1'b1);
    repeat (5) tick(1'b1);
    tick(1'b0);
    post(OP_LINK_DOWN);
    tick(1'b1);

    for (int p = 0; p < 8; p++) begin
      load_config(phase_deb[p], phase_tmo[p]);
      if (p == 3) hold_requests++;
      target = words_sent + PhaseWords;
      while (words_sent < target) talk_session();
    end

    // settings at the counter limit
    load_config(16'd0, CntMax);
    post(OP_LINK_DOWN);
    post(OP_LINK_UP);
    tick(1'b0);
    tick(1'b0);
    tick(1'b1);
    load_config(CntMax, CntMax - 16'd1);
    repeat (4) tick(1'b0);

    wait_idle();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ptfc_pkg.sv
rtl/ptfc_next.sv
rtl/push_to_talk_floor_control.sv
dv/push_to_talk_floor_control_tb.sv
